@@ design/quaternion_arithmetic_unit_macros.svh @@
// ----------------------------------------------------------------------------
// quaternion arithmetic unit assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define QAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/qau_pkg.sv @@
// ----------------------------------------------------------------------------
// qau_pkg
// types, command codes and Q2.13 helpers for the quaternion arithmetic unit
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int QW   = 16;
    localparam int FRAC = 13;
    localparam int PW   = 2 * QW;
    localparam int SW   = PW + 2;

    typedef logic signed [QW-1:0] t_fix;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [SW-1:0] t_sum;

    typedef struct packed {
        t_fix w;
        t_fix x;
        t_fix y;
        t_fix z;
    } t_quat;

    typedef enum logic [1:0] {
        CMD_MUL  = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_CONJ = 2'd2,
        CMD_ROT  = 2'd3
    } t_cmd;

    localparam t_fix FIX_MAX = t_fix'(2 ** (QW - 1) - 1);
    localparam t_fix FIX_MIN = t_fix'(-(2 ** (QW - 1)));

    function automatic t_fix sat_add(input t_fix a, input t_fix b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} + {b[QW-1], b};
        if (s[QW] != s[QW-1]) begin
            return s[QW] ? FIX_MIN : FIX_MAX;
        end
        return s[QW-1:0];
    endfunction

    function automatic t_fix sat_neg(input t_fix a);
        if (a == FIX_MIN) begin
            return FIX_MAX;
        end
        return -a;
    endfunction

    function automatic t_sum ext_prod(input t_prod p);
        return {{(SW - PW){p[PW-1]}}, p};
    endfunction

    // round half up at bit FRAC, then clamp to 16 bits
    function automatic t_fix round_sat(input t_sum s);
        t_sum                   t;
        logic signed [SW-FRAC-1:0] q;
        t = s + t_sum'(2 ** (FRAC - 1));
        q = t[SW-1:FRAC];
        if (q > (SW-FRAC)'(signed'(FIX_MAX))) begin
            return FIX_MAX;
        end
        if (q < (SW-FRAC)'(signed'(FIX_MIN))) begin
            return FIX_MIN;
        end
        return q[QW-1:0];
    endfunction

    function automatic t_quat conj_q(input t_quat a);
        t_quat r;
        r.w = a.w;
        r.x = sat_neg(a.x);
        r.y = sat_neg(a.y);
        r.z = sat_neg(a.z);
        return r;
    endfunction

endpackage

@@ design/qau_ham.sv @@
// ----------------------------------------------------------------------------
// qau_ham
// two-stage Hamilton product: sixteen products, then signed sums with rounding
// ----------------------------------------------------------------------------
module qau_ham (
    input  logic           i_clk,
    input  qau_pkg::t_quat i_a,
    input  qau_pkg::t_quat i_b,
    output qau_pkg::t_quat o_r
);
    import qau_pkg::*;

    t_prod r_ww, r_wx, r_wy, r_wz;
    t_prod r_xw, r_xx, r_xy, r_xz;
    t_prod r_yw, r_yx, r_yy, r_yz;
    t_prod r_zw, r_zx, r_zy, r_zz;
    t_quat r_out;
    t_quat n_out;

    always_ff @(posedge i_clk) begin
        r_ww <= i_a.w * i_b.w;
        r_wx <= i_a.w * i_b.x;
        r_wy <= i_a.w * i_b.y;
        r_wz <= i_a.w * i_b.z;
        r_xw <= i_a.x * i_b.w;
        r_xx <= i_a.x * i_b.x;
        r_xy <= i_a.x * i_b.y;
        r_xz <= i_a.x * i_b.z;
        r_yw <= i_a.y * i_b.w;
        r_yx <= i_a.y * i_b.x;
        r_yy <= i_a.y * i_b.y;
        r_yz <= i_a.y * i_b.z;
        r_zw <= i_a.z * i_b.w;
        r_zx <= i_a.z * i_b.x;
        r_zy <= i_a.z * i_b.y;
        r_zz <= i_a.z * i_b.z;
    end

    always_comb begin
        n_out.w = round_sat(ext_prod(r_ww) - ext_prod(r_xx) - ext_prod(r_yy) - ext_prod(r_zz));
        n_out.x = round_sat(ext_prod(r_wx) + ext_prod(r_xw) + ext_prod(r_yz) - ext_prod(r_zy));
        n_out.y = round_sat(ext_prod(r_wy) - ext_prod(r_xz) + ext_prod(r_yw) + ext_prod(r_zx));
        n_out.z = round_sat(ext_prod(r_wz) + ext_prod(r_xy) - ext_prod(r_yx) + ext_prod(r_zw));
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_r = r_out;

endmodule

@@ design/quaternion_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// pipelined Q2.13 quaternion multiply, add, conjugate and vector rotate
// ----------------------------------------------------------------------------
// usage:
//   drive command and both operands with start high; the item is taken at
//   that clock edge when busy is low. busy stays low, so a new item can be
//   given in every cycle, one per clock sustained.
//   every item gives one result. it shows on o_r_w..o_r_z with o_valid high
//   for exactly one cycle, once its valid bit has passed the r_vld shift
//   register and r_o_valid; results leave in the order items came in.
//   the latency is the same for all commands: the path is set by the rotate,
//   which runs two Hamilton product units in series, each a multiply stage
//   and a sum/round stage, plus an output register.
//   the receiver cannot stall; it has to take each result in its cycle.
//   reset (synchronous, active low) drops every item in flight; o_valid is
//   low the cycle after reset is sampled.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_command,
    input  logic signed [15:0]  i_a_w,
    input  logic signed [15:0]  i_a_x,
    input  logic signed [15:0]  i_a_y,
    input  logic signed [15:0]  i_a_z,
    input  logic signed [15:0]  i_b_w,
    input  logic signed [15:0]  i_b_x,
    input  logic signed [15:0]  i_b_y,
    input  logic signed [15:0]  i_b_z,
    output logic                o_valid,
    output logic signed [15:0]  o_r_w,
    output logic signed [15:0]  o_r_x,
    output logic signed [15:0]  o_r_y,
    output logic signed [15:0]  o_r_z
);
    import qau_pkg::*;

    t_quat      w_a;
    t_quat      w_b;
    t_quat      w_hb;
    t_quat      w_t;
    t_quat      w_v;
    t_cmd       w_cmd;
    t_quat      n_alt;
    t_quat      n_out;

    logic [3:0] r_vld;
    logic       r_o_valid;

    t_cmd       r_s1_cmd, r_s2_cmd, r_s3_cmd, r_s4_cmd;
    t_quat      r_s1_cja, r_s2_cja;
    t_quat      r_s1_alt, r_s2_alt, r_s3_alt, r_s4_alt;
    t_quat      r_s3_t, r_s4_t;
    t_quat      r_out;

    assign busy  = 1'b0;
    assign w_cmd = t_cmd'(i_command);
    assign w_a   = '{w: i_a_w, x: i_a_x, y: i_a_y, z: i_a_z};
    assign w_b   = '{w: i_b_w, x: i_b_x, y: i_b_y, z: i_b_z};

    // rotate multiplies by the pure vector of b
    always_comb begin
        w_hb = w_b;
        if (w_cmd == CMD_ROT) begin
            w_hb.w = '0;
        end
    end

    always_comb begin
        case (w_cmd)
            CMD_ADD: begin
                n_alt.w = sat_add(w_a.w, w_b.w);
                n_alt.x = sat_add(w_a.x, w_b.x);
                n_alt.y = sat_add(w_a.y, w_b.y);
                n_alt.z = sat_add(w_a.z, w_b.z);
            end
            default: begin
                n_alt = conj_q(w_a);
            end
        endcase
    end

    qau_ham u_ham_first (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_hb),
        .o_r   (w_t)
    );

    qau_ham u_ham_second (
        .i_clk (i_clk),
        .i_a   (w_t),
        .i_b   (r_s2_cja),
        .o_r   (w_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_vld     <= {r_vld[2:0], start & ~busy};
            r_o_valid <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cmd <= w_cmd;
        r_s1_cja <= conj_q(w_a);
        r_s1_alt <= n_alt;
        r_s2_cmd <= r_s1_cmd;
        r_s2_cja <= r_s1_cja;
        r_s2_alt <= r_s1_alt;
        r_s3_cmd <= r_s2_cmd;
        r_s3_alt <= r_s2_alt;
        r_s3_t   <= w_t;
        r_s4_cmd <= r_s3_cmd;
        r_s4_alt <= r_s3_alt;
        r_s4_t   <= r_s3_t;
        r_out    <= n_out;
    end

    always_comb begin
        case (r_s4_cmd) inside
            CMD_MUL: begin
                n_out = r_s4_t;
            end
            CMD_ADD, CMD_CONJ: begin
                n_out = r_s4_alt;
            end
            default: begin
                n_out   = w_v;
                n_out.w = '0;
            end
        endcase
    end

    assign o_valid = r_o_valid;
    assign o_r_w   = r_out.w;
    assign o_r_x   = r_out.x;
    assign o_r_y   = r_out.y;
    assign o_r_z   = r_out.z;

endmodule

@@ design/qau_checker.sv @@
// ----------------------------------------------------------------------------
// qau_checker
// port-level checks on result timing and per-command result shape
// ----------------------------------------------------------------------------
`include "quaternion_arithmetic_unit_macros.svh"

module qau_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic [1:0]          i_command,
    input logic signed [15:0]  i_a_w,
    input logic                o_valid,
    input logic signed [15:0]  o_r_w
);
    import qau_pkg::*;

    logic w_xfer;

    assign w_xfer = start & ~busy;

    // every input transfer gives a result strobe on o_valid
    `QAU_ASSERT_IMP(a_latency, i_clk, i_rst_n, w_xfer, ##5 o_valid, "result strobe missing")

    // no result without a matching input transfer
    `QAU_ASSERT_IMP(a_no_extra, i_clk, i_rst_n, o_valid, $past(w_xfer, 5), "spurious result strobe")

    // rotate returns a pure vector
    `QAU_ASSERT_IMP(a_rot_w, i_clk, i_rst_n, o_valid && $past(i_command, 5) == CMD_ROT, o_r_w == '0, "rotate scalar not zero")

    // conjugate keeps the scalar part of a
    `QAU_ASSERT_IMP(a_conj_w, i_clk, i_rst_n, o_valid && $past(i_command, 5) == CMD_CONJ, o_r_w == $past(i_a_w, 5), "conjugate scalar changed")

    // the unit never holds off the sender
    `QAU_ASSERT_NXT(a_busy, i_clk, i_rst_n, 1'b1, !busy, "busy raised")

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_command (i_command),
    .i_a_w     (i_a_w),
    .o_valid   (o_valid),
    .o_r_w     (o_r_w)
);
